@@ sv/mcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcsr_pkg: shared types and constants of the sparse matrix-vector block
// Command codes, field widths and the Q16.16 rounding and clipping helpers.
// ----------------------------------------------------------------------------
package mcsr_pkg;

   localparam int unsigned IDX_W    = 10;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ACC_W    = 64;
   localparam int unsigned DEPTH    = 1024;
   localparam int unsigned MAX_ROWS = 1024;
   localparam int unsigned CNT_W    = 17;

   typedef logic [1:0]              cmd_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic signed [DATA_W-1:0] q16_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   localparam cmd_type CMD_LOAD = 2'd0;
   localparam cmd_type CMD_DIAG = 2'd1;
   localparam cmd_type CMD_OFFD = 2'd2;

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_SCALE = 1'b1;

   localparam q16_type SCALE_RESET = 32'sd65536;
   localparam q16_type Q16_MAX     = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN     = 32'sh8000_0000;

   typedef struct packed {
      q16_type val;
      logic    sat;
   } clip_type;

   // Q32.32 to Q16.16: add half an LSB, then shift right arithmetically.
   function automatic logic signed [48:0] round16(input acc_type x);
      logic [48:0] r;
      r = {x[63], x[63:16]} + {48'd0, x[15]};
      return $signed(r);
   endfunction

   // Clip a 50-bit signed value to the 32-bit range.
   function automatic clip_type clip32(input logic signed [49:0] x);
      clip_type c;
      if ((x[49:31] != {19{1'b0}}) && (x[49:31] != {19{1'b1}})) begin
         c.sat = 1'b1;
         c.val = x[49] ? Q16_MIN : Q16_MAX;
      end else begin
         c.sat = 1'b0;
         c.val = $signed(x[31:0]);
      end
      return c;
   endfunction

endpackage

@@ sv/mcsr_sparse_matvec_top.sv @@
// ----------------------------------------------------------------------------
// mcsr_sparse_matvec_top: streaming sparse matrix-vector product (MCSR order)
// Loads x into a 1024-entry store, then accumulates each row's products and
// emits y per row, optionally scaled and added to a prior value.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/req_ready, cmd, index, value, | in
//          | prior, row_last                         |
//  rsp     | rsp_valid/rsp_ready, row_number,        | out
//          | y_value, saturated                      |
//  csr     | csr_write_enable, csr_index, csr_write_data | in (write only)
//
// A load or an unused command leaves the block idle; a matrix entry steps
// through store read, multiply and accumulate. A row's last entry adds a
// rounding and an emit step, plus in accumulate mode the second multiply,
// its rounding and the prior add. One item is in flight at a time; the result
// waits in an output register, so a stalled rsp side holds only a row end.
// Sync reset clears state, row count/sum, sat_seen, rsp_valid and CSRs only.
// ----------------------------------------------------------------------------
module mcsr_sparse_matvec_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mcsr_pkg::cmd_type      req_cmd,
   input  mcsr_pkg::idx_type      req_index,
   input  mcsr_pkg::q16_type      req_value,
   input  mcsr_pkg::q16_type      req_prior,
   input  logic                   req_row_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mcsr_pkg::idx_type      rsp_row_number,
   output mcsr_pkg::q16_type      rsp_y_value,
   output logic                   rsp_saturated,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  mcsr_pkg::q16_type      csr_write_data
);
   import mcsr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_RND  = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_RND2 = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic                mode_ff;
   q16_type             scale_ff;
   idx_type             row_cnt_ff, row_cnt_in;
   acc_type             row_sum_ff, row_sum_in;
   logic                sat_seen_ff, sat_seen_in;
   logic                diag_ff, diag_in;
   logic                last_ff, last_in;
   q16_type             value_ff, value_in;
   q16_type             prior_ff, prior_in;
   acc_type             prod_ff, prod_in;
   q16_type             s_ff, s_in;
   logic                sat_ff, sat_in;
   logic signed [48:0]  t_ff, t_in;
   q16_type             y_ff, y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   idx_type             rsp_row_ff, rsp_row_in;
   q16_type             rsp_y_ff, rsp_y_in;
   logic                rsp_sat_ff, rsp_sat_in;

   q16_type             mem [0:DEPTH-1];
   q16_type             rd_data_ff;
   logic                accept, wr_en, rd_en;
   idx_type             rd_addr;

   acc_type             acc_base;
   logic [ACC_W:0]      acc_sum;
   logic signed [48:0]  rnd_sum;
   clip_type            c1, c2;
   logic [CNT_W-1:0]    cnt_next;
   logic                out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_cmd == CMD_LOAD);
   assign rd_en     = accept && ((req_cmd == CMD_DIAG) || (req_cmd == CMD_OFFD));
   assign rd_addr   = (req_cmd == CMD_DIAG) ? row_cnt_ff : req_index;

   // Vector store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_index] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         scale_ff <= SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_write_data[0];
            CSR_SCALE: scale_ff <= csr_write_data;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   // A diagonal entry starts the row from zero.
   assign acc_base = diag_ff ? '0 : row_sum_ff;
   assign acc_sum  = {acc_base[ACC_W-1], acc_base} + {prod_ff[ACC_W-1], prod_ff};
   assign rnd_sum  = round16(row_sum_ff);
   assign c1       = clip32({rnd_sum[48], rnd_sum});
   assign c2       = clip32({t_ff[48], t_ff} + {{18{prior_ff[31]}}, prior_ff});
   assign cnt_next = {{(CNT_W-IDX_W){1'b0}}, row_cnt_ff} + {{(CNT_W-1){1'b0}}, 1'b1};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      row_sum_in   = row_sum_ff;
      sat_seen_in  = sat_seen_ff;
      diag_in      = diag_ff;
      last_in      = last_ff;
      value_in     = value_ff;
      prior_in     = prior_ff;
      prod_in      = prod_ff;
      s_in         = s_ff;
      sat_in       = sat_ff;
      t_in         = t_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               diag_in  = (req_cmd == CMD_DIAG);
               last_in  = req_row_last;
               value_in = req_value;
               prior_in = req_prior;
               if (req_cmd == CMD_LOAD) begin
                  row_cnt_in = '0;
               end else if (rd_en) begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            prod_in  = value_ff * rd_data_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            sat_seen_in = diag_ff ? 1'b0 : sat_seen_ff;
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               row_sum_in  = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
               sat_seen_in = 1'b1;
            end else begin
               row_sum_in = acc_sum[ACC_W-1:0];
            end
            state_in = last_ff ? S_RND : S_IDLE;
         end
         S_RND: begin
            s_in     = c1.val;
            sat_in   = sat_seen_ff | c1.sat;
            y_in     = c1.val;
            state_in = mode_ff ? S_MUL2 : S_OUT;
         end
         S_MUL2: begin
            prod_in  = scale_ff * s_ff;
            state_in = S_RND2;
         end
         S_RND2: begin
            t_in     = round16(prod_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            y_in     = c2.val;
            sat_in   = sat_ff | c2.sat;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_cnt_ff;
               rsp_y_in     = y_ff;
               rsp_sat_in   = sat_ff;
               row_cnt_in   = (cnt_next >= CNT_W'(MAX_ROWS)) ? '0 : cnt_next[IDX_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_cnt_ff   <= '0;
         row_sum_ff   <= '0;
         sat_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         row_sum_ff   <= row_sum_in;
         sat_seen_ff  <= sat_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff    <= diag_in;
      last_ff    <= last_in;
      value_ff   <= value_in;
      prior_ff   <= prior_in;
      prod_ff    <= prod_in;
      s_ff       <= s_in;
      sat_ff     <= sat_in;
      t_ff       <= t_in;
      y_ff       <= y_in;
      rsp_row_ff <= rsp_row_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_number = rsp_row_ff;
   assign rsp_y_value    = rsp_y_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // A load always restarts the row count.
   a_load_clears_rows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_LOAD)) |=> (row_cnt_ff == '0))
      else $error("row counter not cleared by a load");

   // A matrix entry always starts with the store read.
   a_entry_reads: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == S_RD))
      else $error("matrix entry did not enter the read cycle");

   // A new result word only ever comes out of the emit state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready) && !$past(reset))
      |-> ($past(state_ff) == S_OUT))
      else $error("result word raised outside the emit state");

endmodule
